[hdl/mcdd_pkg.sv]
// Package for the mouse click and double-click detector.
// Holds widths, button and register codes and the result word type.
// No dependencies.
`timescale 1ns / 1ps

package mcdd_pkg;

  localparam int NUM_BUTTONS   = 3;
  localparam int SAMPLE_FIELDS = 3;
  localparam int ACTIVE_BUTTONS =
    (NUM_BUTTONS < SAMPLE_FIELDS) ? NUM_BUTTONS : SAMPLE_FIELDS;

  localparam int MASK_W    = 3;
  localparam int LEVEL_W   = 2;
  localparam int TIMER_W   = 16;
  localparam int ELAPSED_W = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  // Bit positions inside one button level.
  localparam int LVL_DOWN_BIT = 0;
  localparam int LVL_UP_BIT   = 1;
  localparam logic [LEVEL_W-1:0] LVL_UP_ONLY = 2'b10;

  // Input mode codes.
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CLICK_INTERVAL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_INTERVAL = 2'd1;

  localparam logic [TIMER_W-1:0] CLICK_INTERVAL_RST  = 16'd250;
  localparam logic [TIMER_W-1:0] DOUBLE_INTERVAL_RST = 16'd500;

  typedef struct packed {
    logic [MASK_W-1:0] down;
    logic [MASK_W-1:0] up;
    logic [MASK_W-1:0] pressed;
    logic [MASK_W-1:0] released;
    logic [MASK_W-1:0] clicked;
    logic [MASK_W-1:0] dbl;
  } result_t;

endpackage

[hdl/mouse_click_double_click_detector_unit.sv]
// Usage notes for the mouse click and double-click detector.
// Input channel (in_valid / in_stall): one word is either a button sample
// (in_mode = 0) or a time tick (in_mode = 1) carrying in_elapsed_ms.
// Output channel (out_valid / out_stall): one word per button sample with
// the down, up, pressed, released, clicked and double-clicked masks.
// Ticks advance the shared timers (only while a click is pending) and give
// no output word.
// Configuration channel (cfg_valid / cfg_ready): cfg_ready is always high;
// index 0 sets click_interval, index 1 double_click_interval, others are
// ignored. Write only while the block is idle.
// A sample's result is registered into the output queue at the edge that
// accepts it. Throughput: one word per cycle while in_stall is low; the
// detector state updates in one pass of logic at the accepting edge.
// A two-entry output queue lets a new word enter while a result waits; with
// both entries full in_stall is raised until the receiver takes a word.
// Reset (rst_n low, synchronous) marks all buttons up, clears the pending
// flags and timers, empties the queue and restores the interval defaults.
`timescale 1ns / 1ps

module mouse_click_double_click_detector_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_mode,
  input  logic [mcdd_pkg::LEVEL_W-1:0]  in_button0_level,
  input  logic [mcdd_pkg::LEVEL_W-1:0]  in_button1_level,
  input  logic [mcdd_pkg::LEVEL_W-1:0]  in_button2_level,
  input  logic [mcdd_pkg::ELAPSED_W-1:0] in_elapsed_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mcdd_pkg::MASK_W-1:0]   out_down_mask,
  output logic [mcdd_pkg::MASK_W-1:0]   out_up_mask,
  output logic [mcdd_pkg::MASK_W-1:0]   out_pressed_mask,
  output logic [mcdd_pkg::MASK_W-1:0]   out_released_mask,
  output logic [mcdd_pkg::MASK_W-1:0]   out_clicked_mask,
  output logic [mcdd_pkg::MASK_W-1:0]   out_double_clicked_mask,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mcdd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mcdd_pkg::TIMER_W-1:0]  cfg_data
);
  import mcdd_pkg::*;

  logic [TIMER_W-1:0] click_interval_r;
  logic [TIMER_W-1:0] double_interval_r;

  logic [LEVEL_W-1:0] prev_r   [ACTIVE_BUTTONS];
  logic [LEVEL_W-1:0] prev_nxt [ACTIVE_BUTTONS];
  logic [LEVEL_W-1:0] sample   [SAMPLE_FIELDS];

  logic               click_pending_r, click_pending_nxt;
  logic               double_pending_r, double_pending_nxt;
  logic [TIMER_W-1:0] click_timer_r, click_timer_nxt;
  logic [TIMER_W-1:0] double_timer_r, double_timer_nxt;

  result_t main_r, skid_r, res;
  logic    main_valid_r, skid_valid_r;

  logic in_acc, push, out_take;
  logic [TIMER_W:0] click_sum, double_sum;

  assign sample[0] = in_button0_level;
  assign sample[1] = in_button1_level;
  assign sample[2] = in_button2_level;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !in_stall;
  assign push      = in_acc && (in_mode == MODE_SAMPLE);
  assign out_take  = main_valid_r && !out_stall;

  assign click_sum  = {1'b0, click_timer_r} + (TIMER_W + 1)'(in_elapsed_ms);
  assign double_sum = {1'b0, double_timer_r} + (TIMER_W + 1)'(in_elapsed_ms);

  // Buttons are handled in order; each one sees the flags and timers that
  // the lower-numbered buttons of the same sample left behind.
  always_comb begin
    logic             cp, dp, now_down, now_up, last_down, last_up;
    logic [TIMER_W-1:0] ct, dt;
    cp  = click_pending_r;
    dp  = double_pending_r;
    ct  = click_timer_r;
    dt  = double_timer_r;
    now_down  = 1'b0;
    now_up    = 1'b0;
    last_down = 1'b0;
    last_up   = 1'b0;
    res = '0;
    for (int k = 0; k < ACTIVE_BUTTONS; k++) begin
      prev_nxt[k] = prev_r[k];
    end
    if (in_mode == MODE_TICK) begin
      if (click_pending_r) begin
        ct = click_sum[TIMER_W] ? TIMER_MAX : click_sum[TIMER_W-1:0];
        dt = double_sum[TIMER_W] ? TIMER_MAX : double_sum[TIMER_W-1:0];
      end
    end else begin
      for (int k = 0; k < ACTIVE_BUTTONS; k++) begin
        now_down    = sample[k][LVL_DOWN_BIT];
        now_up      = sample[k][LVL_UP_BIT];
        last_down   = prev_r[k][LVL_DOWN_BIT];
        last_up     = prev_r[k][LVL_UP_BIT];
        prev_nxt[k] = sample[k];
        if (now_down) begin
          res.down[k] = 1'b1;
          if (last_up) begin
            res.pressed[k] = 1'b1;
            if (cp) begin
              dp = 1'b1;
            end
            cp = 1'b1;
            ct = '0;
          end
        end
        if (now_up) begin
          res.up[k] = 1'b1;
          if (last_down) begin
            res.released[k] = 1'b1;
            if (dp && (dt < double_interval_r)) begin
              res.dbl[k] = 1'b1;
            end
            dp = 1'b0;
            if (cp && (ct < click_interval_r)) begin
              res.clicked[k] = 1'b1;
              dt = '0;
            end else begin
              cp = 1'b0;
            end
          end
        end
      end
    end
    click_pending_nxt  = cp;
    double_pending_nxt = dp;
    click_timer_nxt    = ct;
    double_timer_nxt   = dt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      click_interval_r  <= CLICK_INTERVAL_RST;
      double_interval_r <= DOUBLE_INTERVAL_RST;
      click_pending_r   <= 1'b0;
      double_pending_r  <= 1'b0;
      click_timer_r     <= '0;
      double_timer_r    <= '0;
      for (int k = 0; k < ACTIVE_BUTTONS; k++) begin
        prev_r[k] <= LVL_UP_ONLY;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_CLICK_INTERVAL) begin
          click_interval_r <= cfg_data;
        end else if (cfg_index == CFG_DOUBLE_INTERVAL) begin
          double_interval_r <= cfg_data;
        end
      end
      if (in_acc) begin
        click_pending_r  <= click_pending_nxt;
        double_pending_r <= double_pending_nxt;
        click_timer_r    <= click_timer_nxt;
        double_timer_r   <= double_timer_nxt;
        for (int k = 0; k < ACTIVE_BUTTONS; k++) begin
          prev_r[k] <= prev_nxt[k];
        end
      end
    end
  end

  // Two-entry result queue: the main word drives the ports, the skid word
  // catches a result that arrives while the main word is stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_take || !main_valid_r) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= push;
      end else begin
        main_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take || !main_valid_r) begin
      if (skid_valid_r) begin
        main_r <= skid_r;
        skid_r <= res;
      end else begin
        main_r <= res;
      end
    end else if (push) begin
      skid_r <= res;
    end
  end

  assign out_valid               = main_valid_r;
  assign out_down_mask           = main_r.down;
  assign out_up_mask             = main_r.up;
  assign out_pressed_mask        = main_r.pressed;
  assign out_released_mask       = main_r.released;
  assign out_clicked_mask        = main_r.clicked;
  assign out_double_clicked_mask = main_r.dbl;

`ifndef SYNTHESIS
  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid word held without a main word");

  a_click_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_clicked_mask & ~out_released_mask) == '0))
    else $error("click reported without a release");

  a_double_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_double_clicked_mask & ~out_released_mask) == '0))
    else $error("double click reported without a release");

  a_tick_idle_timers: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_mode == MODE_TICK) && !click_pending_r) |=>
      ($stable(click_timer_r) && $stable(double_timer_r)))
    else $error("timer moved while no click was pending");
`endif

endmodule

[sim/tb.sv]
// Self-checking bench for mouse_click_double_click_detector_unit.
// Holds a click-detector scoreboard class and the drive tasks. Depends on
// mcdd_pkg and the detector RTL only.
`timescale 1ns / 1ps

module tb;
  import mcdd_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 60;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [ELAPSED_W-1:0] MAX_MS = 10'd1000;

  localparam logic [LEVEL_W-1:0] LV_NONE = 2'b00;
  localparam logic [LEVEL_W-1:0] LV_DOWN = 2'b01;
  localparam logic [LEVEL_W-1:0] LV_BOTH = 2'b11;

  // Indexes past the register list; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  class click_scoreboard;
    logic [TIMER_W-1:0] click_limit;
    logic [TIMER_W-1:0] double_limit;
    logic [LEVEL_W-1:0] last_level [NUM_BUTTONS];
    bit                 click_armed;
    bit                 double_armed;
    logic [TIMER_W-1:0] press_age;
    logic [TIMER_W-1:0] click_age;
    result_t            due_masks [$];
    int unsigned        n_checked, n_bad, n_samples, n_ticks, n_clicks, n_doubles;

    function new();
      int k;
      for (k = 0; k < NUM_BUTTONS; k++) last_level[k] = LVL_UP_ONLY;
      click_limit  = CLICK_INTERVAL_RST;
      double_limit = DOUBLE_INTERVAL_RST;
      click_armed  = 1'b0;
      double_armed = 1'b0;
      press_age    = '0;
      click_age    = '0;
      n_checked = 0; n_bad = 0; n_samples = 0; n_ticks = 0; n_clicks = 0; n_doubles = 0;
    endfunction

    function logic [TIMER_W-1:0] sat_add(logic [TIMER_W-1:0] a, logic [ELAPSED_W-1:0] b);
      logic [TIMER_W:0] sum;
      sum = {1'b0, a} + (TIMER_W + 1)'(b);
      return (sum > {1'b0, TIMER_MAX}) ? TIMER_MAX : sum[TIMER_W-1:0];
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIMER_W-1:0] val);
      case (idx)
        CFG_CLICK_INTERVAL:  click_limit = val;
        CFG_DOUBLE_INTERVAL: double_limit = val;
        default: ;
      endcase
    endfunction

    function void predict_word(logic mode, logic [LEVEL_W-1:0] l0, logic [LEVEL_W-1:0] l1,
                               logic [LEVEL_W-1:0] l2, logic [ELAPSED_W-1:0] ms);
      logic [LEVEL_W-1:0] now [SAMPLE_FIELDS];
      logic [LEVEL_W-1:0] was;
      result_t r;
      int k;
      if (mode == MODE_TICK) begin
        n_ticks++;
        // Both timers only run while a click is pending.
        if (click_armed) begin
          press_age = sat_add(press_age, ms);
          click_age = sat_add(click_age, ms);
        end
        return;
      end
      n_samples++;
      now[0] = l0;
      now[1] = l1;
      now[2] = l2;
      r = '0;
      for (k = 0; k < ACTIVE_BUTTONS; k++) begin
        was = last_level[k];
        last_level[k] = now[k];
        // The down bit is handled before the up bit of the same sample.
        if (now[k][LVL_DOWN_BIT]) begin
          r.down[k] = 1'b1;
          if (was[LVL_UP_BIT]) begin
            r.pressed[k] = 1'b1;
            if (click_armed) double_armed = 1'b1;
            click_armed = 1'b1;
            press_age = '0;
          end
        end
        if (now[k][LVL_UP_BIT]) begin
          r.up[k] = 1'b1;
          if (was[LVL_DOWN_BIT]) begin
            r.released[k] = 1'b1;
            if (double_armed && click_age < double_limit) r.dbl[k] = 1'b1;
            double_armed = 1'b0;
            if (click_armed && press_age < click_limit) begin
              r.clicked[k] = 1'b1;
              click_age = '0;
            end else begin
              click_armed = 1'b0;
            end
          end
        end
      end
      if (r.clicked != '0) n_clicks++;
      if (r.dbl != '0) n_doubles++;
      due_masks.push_back(r);
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (due_masks.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("%0t: result word with none outstanding: dn=%b up=%b pr=%b rl=%b ck=%b db=%b",
                   $time, got.down, got.up, got.pressed, got.released, got.clicked, got.dbl);
        return;
      end
      want = due_masks.pop_front();
      n_checked++;
      if (got.down !== want.down || got.up !== want.up || got.pressed !== want.pressed ||
          got.released !== want.released || got.clicked !== want.clicked ||
          got.dbl !== want.dbl) begin
        n_bad++;
        if (n_bad <= 10) begin
          $display("%0t: mismatch, want dn=%b up=%b pr=%b rl=%b ck=%b db=%b", $time,
                   want.down, want.up, want.pressed, want.released, want.clicked, want.dbl);
          $display("%0t:             got dn=%b up=%b pr=%b rl=%b ck=%b db=%b", $time,
                   got.down, got.up, got.pressed, got.released, got.clicked, got.dbl);
        end
      end
    endfunction

    function int pending();
      return due_masks.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_mode;
  logic [LEVEL_W-1:0]   in_button0_level;
  logic [LEVEL_W-1:0]   in_button1_level;
  logic [LEVEL_W-1:0]   in_button2_level;
  logic [ELAPSED_W-1:0] in_elapsed_ms;
  logic                 out_valid;
  logic                 out_stall;
  logic [MASK_W-1:0]    out_down_mask;
  logic [MASK_W-1:0]    out_up_mask;
  logic [MASK_W-1:0]    out_pressed_mask;
  logic [MASK_W-1:0]    out_released_mask;
  logic [MASK_W-1:0]    out_clicked_mask;
  logic [MASK_W-1:0]    out_double_clicked_mask;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TIMER_W-1:0]   cfg_data;

  click_scoreboard      sb;
  logic [LEVEL_W-1:0]   stim_lv [SAMPLE_FIELDS];
  int unsigned          words_sent;
  int unsigned          settings_used;
  int unsigned          cycle_count;
  bit                   gaps_on;
  bit                   stalls_on;
  bit                   hold_req;

  mouse_click_double_click_detector_unit i_dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_mode                 (in_mode),
    .in_button0_level        (in_button0_level),
    .in_button1_level        (in_button1_level),
    .in_button2_level        (in_button2_level),
    .in_elapsed_ms           (in_elapsed_ms),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_down_mask           (out_down_mask),
    .out_up_mask             (out_up_mask),
    .out_pressed_mask        (out_pressed_mask),
    .out_released_mask       (out_released_mask),
    .out_clicked_mask        (out_clicked_mask),
    .out_double_clicked_mask (out_double_clicked_mask),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d result words outstanding.",
               cycle_count, sb.pending());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Inputs are noted before the result is checked, so a word accepted and
  // answered at the same edge would still line up.
  always @(posedge clk) begin
    result_t got;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall)
        sb.predict_word(in_mode, in_button0_level, in_button1_level, in_button2_level,
                        in_elapsed_ms);
      if (out_valid && !out_stall) begin
        got.down     = out_down_mask;
        got.up       = out_up_mask;
        got.pressed  = out_pressed_mask;
        got.released = out_released_mask;
        got.clicked  = out_clicked_mask;
        got.dbl      = out_double_clicked_mask;
        sb.check_word(got);
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (stalls_on && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input logic mode, input logic [LEVEL_W-1:0] l0,
                           input logic [LEVEL_W-1:0] l1, input logic [LEVEL_W-1:0] l2,
                           input logic [ELAPSED_W-1:0] ms);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_mode          <= mode;
    in_button0_level <= l0;
    in_button1_level <= l1;
    in_button2_level <= l2;
    in_elapsed_ms    <= ms;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic send_sample();
    send_word(MODE_SAMPLE, stim_lv[0], stim_lv[1], stim_lv[2],
              ELAPSED_W'($urandom_range(0, MAX_MS)));
  endtask

  task automatic sample3(input logic [LEVEL_W-1:0] l0, input logic [LEVEL_W-1:0] l1,
                         input logic [LEVEL_W-1:0] l2);
    stim_lv[0] = l0;
    stim_lv[1] = l1;
    stim_lv[2] = l2;
    send_sample();
  endtask

  // Button fields are don't-care on a tick, so they carry random values.
  task automatic send_tick(input logic [ELAPSED_W-1:0] ms);
    send_word(MODE_TICK, LEVEL_W'($urandom_range(0, 3)), LEVEL_W'($urandom_range(0, 3)),
              LEVEL_W'($urandom_range(0, 3)), ms);
  endtask

  function automatic logic [ELAPSED_W-1:0] pick_ms();
    int sel;
    sel = $urandom_range(0, 4);
    if (sel == 0) return '0;
    if (sel == 1) return ELAPSED_W'($urandom_range(1, 40));
    if (sel == 2) return ELAPSED_W'($urandom_range(0, 300));
    if (sel == 3) return ELAPSED_W'($urandom_range(0, MAX_MS));
    return MAX_MS;
  endfunction

  // One to three press/release pairs, mostly on one button, with optional ticks between.
  task automatic click_run();
    int b;
    int n;
    int j;
    b = $urandom_range(0, ACTIVE_BUTTONS - 1);
    n = $urandom_range(1, 3);
    for (j = 0; j < n; j++) begin
      stim_lv[b] = ($urandom_range(0, 9) == 0) ? LV_BOTH : LV_DOWN;
      send_sample();
      repeat ($urandom_range(0, 2)) send_tick(pick_ms());
      stim_lv[b] = ($urandom_range(0, 9) == 0) ? LV_BOTH : LVL_UP_ONLY;
      send_sample();
      repeat ($urandom_range(0, 2)) send_tick(pick_ms());
      if ($urandom_range(0, 5) == 0) b = $urandom_range(0, ACTIVE_BUTTONS - 1);
    end
  endtask

  task automatic noise_word();
    int k;
    if ($urandom_range(0, 1)) begin
      send_tick(ELAPSED_W'($urandom_range(0, MAX_MS)));
    end else begin
      for (k = 0; k < SAMPLE_FIELDS; k++) stim_lv[k] = LEVEL_W'($urandom_range(0, 3));
      send_sample();
    end
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned start;
    start = words_sent;
    while (words_sent - start < n) begin
      if ($urandom_range(0, 9) < 7) click_run();
      else noise_word();
    end
  endtask

  // Stop offering and wait for every result; ticks may still be in flight.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Keeps the write valid high across the three words; lowered once at the end.
  task automatic program_intervals(input logic [TIMER_W-1:0] click_ms,
                                   input logic [TIMER_W-1:0] dbl_ms);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [TIMER_W-1:0]   val [3];
    int i;
    idx[0] = CFG_CLICK_INTERVAL;
    val[0] = click_ms;
    idx[1] = $urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B;
    val[1] = TIMER_W'($urandom);
    idx[2] = CFG_DOUBLE_INTERVAL;
    val[2] = dbl_ms;
    for (i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int k;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_SAMPLE;
    in_button0_level = LVL_UP_ONLY;
    in_button1_level = LVL_UP_ONLY;
    in_button2_level = LVL_UP_ONLY;
    in_elapsed_ms = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_CLICK_INTERVAL;
    cfg_data = '0;
    for (k = 0; k < SAMPLE_FIELDS; k++) stim_lv[k] = LVL_UP_ONLY;
    words_sent = 0;
    settings_used = 1;
    cycle_count = 0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    hold_req = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words at the default intervals of 250 and 500 ms.
    send_tick(MAX_MS);                               // nothing pending, timers stay put
    sample3(LVL_UP_ONLY, LVL_UP_ONLY, LVL_UP_ONLY);
    sample3(LV_DOWN, LVL_UP_ONLY, LVL_UP_ONLY);
    send_tick(10'd100);
    sample3(LVL_UP_ONLY, LVL_UP_ONLY, LVL_UP_ONLY);  // click
    send_tick(10'd200);
    sample3(LV_DOWN, LVL_UP_ONLY, LVL_UP_ONLY);
    send_tick('0);
    sample3(LVL_UP_ONLY, LVL_UP_ONLY, LVL_UP_ONLY);  // click and double click
    sample3(LVL_UP_ONLY, LV_DOWN, LVL_UP_ONLY);
    send_tick(MAX_MS);
    sample3(LVL_UP_ONLY, LVL_UP_ONLY, LVL_UP_ONLY);  // held too long
    sample3(LV_DOWN, LV_DOWN, LVL_UP_ONLY);
    send_tick(10'd300);
    sample3(LVL_UP_ONLY, LV_DOWN, LVL_UP_ONLY);      // fails and clears the pending click
    sample3(LVL_UP_ONLY, LVL_UP_ONLY, LVL_UP_ONLY);  // release with nothing pending
    sample3(LV_BOTH, LV_BOTH, LV_BOTH);              // press only; no release, as the last level had no down bit
    sample3(LV_NONE, LV_NONE, LV_NONE);
    sample3(LVL_UP_ONLY, LVL_UP_ONLY, LVL_UP_ONLY);  // no edge out of an empty level
    sample3(LV_DOWN, LV_DOWN, LV_DOWN);
    send_tick(10'd1);
    sample3(LV_BOTH, LV_BOTH, LV_BOTH);              // release only, no fresh press
    sample3(LVL_UP_ONLY, LVL_UP_ONLY, LVL_UP_ONLY);

    run_random(100);
    // Long receiver hold while words keep coming, so the block backs up.
    gaps_on = 1'b0;
    hold_req = 1'b1;
    repeat (25) noise_word();
    gaps_on = 1'b1;
    run_random(100);
    settle();

    program_intervals('0, '0);
    run_random(150);
    settle();

    program_intervals(TIMER_MAX, TIMER_MAX);
    // Drive both timers into saturation; the limits are then just missed.
    sample3(LVL_UP_ONLY, LVL_UP_ONLY, LV_DOWN);
    repeat (70) send_tick(MAX_MS);
    sample3(LVL_UP_ONLY, LVL_UP_ONLY, LVL_UP_ONLY);
    sample3(LV_DOWN, LVL_UP_ONLY, LVL_UP_ONLY);
    sample3(LVL_UP_ONLY, LVL_UP_ONLY, LVL_UP_ONLY);
    sample3(LV_DOWN, LVL_UP_ONLY, LVL_UP_ONLY);
    repeat (70) send_tick(MAX_MS);
    sample3(LVL_UP_ONLY, LVL_UP_ONLY, LVL_UP_ONLY);
    run_random(120);
    settle();

    program_intervals(16'd1, 16'd1);
    run_random(150);
    settle();

    program_intervals(TIMER_W'($urandom_range(0, MAX_MS)),
                      TIMER_W'($urandom_range(0, MAX_MS)));
    run_random(100);
    settle();                                        // sender waits for every result
    run_random(100);
    settle();

    program_intervals(TIMER_W'($urandom), TIMER_W'($urandom));
    run_random(120);
    settle();

    // Last stretch at the defaults with no idling on either side.
    program_intervals(CLICK_INTERVAL_RST, DOUBLE_INTERVAL_RST);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    run_random(230);
    settle();

    repeat (10) @(posedge clk);
    $display("Sent %0d words (%0d samples, %0d ticks) under %0d interval settings.",
             words_sent, sb.n_samples, sb.n_ticks, settings_used);
    $display("Checked %0d result words holding %0d clicks and %0d double clicks; %0d errors.",
             sb.n_checked, sb.n_clicks, sb.n_doubles, sb.n_bad);
    if (sb.n_bad == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
